>>> design/tatc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor linearisation package
// Widths, the segment table and the structs passed between pipeline parts.
// ----------------------------------------------------------------------------
package tatc_pkg;

    localparam int SAMPLE_W             = 12;
    localparam int TEMP_W               = 8;
    localparam int ADC_W                = 10;
    localparam int TDIFF_W              = 3;
    localparam int QUOT_W               = 3;
    localparam int NUM_W                = ADC_W + TDIFF_W;
    localparam int SPAN_W               = ADC_W;
    localparam int DIV_W                = (NUM_W > SPAN_W + QUOT_W) ? NUM_W : SPAN_W + QUOT_W;
    localparam int TABLE_ROWS           = 18;
    localparam int TBL_IDX_W            = $clog2(TABLE_ROWS);
    localparam int NUM_SEGMENTS_DEFAULT = 18;

    typedef struct packed {
        logic signed [TEMP_W-1:0] t_hi;
        logic signed [TEMP_W-1:0] t_lo;
        logic [ADC_W-1:0]         a_hi;
        logic [ADC_W-1:0]         a_lo;
    } seg_row_t;

    localparam seg_row_t SEG_TABLE [TABLE_ROWS] = '{
        '{-8'sd15, -8'sd20, 10'd682, 10'd536},
        '{-8'sd10, -8'sd15, 10'd536, 10'd425},
        '{-8'sd5,  -8'sd10, 10'd425, 10'd338},
        '{ 8'sd0,  -8'sd5,  10'd338, 10'd272},
        '{ 8'sd5,   8'sd0,  10'd272, 10'd220},
        '{ 8'sd10,  8'sd5,  10'd220, 10'd179},
        '{ 8'sd15,  8'sd10, 10'd179, 10'd146},
        '{ 8'sd20,  8'sd15, 10'd146, 10'd120},
        '{ 8'sd25,  8'sd20, 10'd120, 10'd100},
        '{ 8'sd30,  8'sd25, 10'd100, 10'd83},
        '{ 8'sd35,  8'sd30, 10'd83,  10'd69},
        '{ 8'sd40,  8'sd35, 10'd69,  10'd58},
        '{ 8'sd45,  8'sd40, 10'd58,  10'd49},
        '{ 8'sd50,  8'sd45, 10'd49,  10'd41},
        '{ 8'sd55,  8'sd50, 10'd41,  10'd35},
        '{ 8'sd60,  8'sd55, 10'd35,  10'd30},
        '{ 8'sd65,  8'sd60, 10'd30,  10'd25},
        '{ 8'sd70,  8'sd65, 10'd25,  10'd22}
    };

    // Product of the segment position and the temperature step.
    typedef struct packed {
        logic [NUM_W-1:0]         num;
        logic [SPAN_W-1:0]        span;
        logic signed [TEMP_W-1:0] t_lo;
        logic                     hit;
    } tatc_prod_t;

    // Interpolation quotient ready for the final add.
    typedef struct packed {
        logic [QUOT_W-1:0]        quot;
        logic signed [TEMP_W-1:0] t_lo;
        logic                     hit;
    } tatc_quot_t;

    // Working state of one divider stage.
    typedef struct packed {
        logic [DIV_W-1:0]         rem;
        logic [QUOT_W-1:0]        quot;
        logic [SPAN_W-1:0]        span;
        logic signed [TEMP_W-1:0] t_lo;
        logic                     hit;
    } div_stage_t;

endpackage

>>> design/tatc_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one raw thermistor converter reading a beat.
// ----------------------------------------------------------------------------
interface tatc_sample_if;
    import tatc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

>>> design/tatc_temp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature channel
// Valid/ready channel carrying one temperature and its range flag a beat.
// ----------------------------------------------------------------------------
interface tatc_temp_if;
    import tatc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_c;
    logic                     out_of_range;

    modport source (output valid, output temperature_c, output out_of_range, input ready);
    modport sink   (input valid, input temperature_c, input out_of_range, output ready);
endinterface

>>> design/thermistor_adc_to_temperature.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermistor converter reading to temperature
// Piecewise-linear linearisation of a battery thermistor sample.
// ----------------------------------------------------------------------------
// The block takes one 12-bit thermistor reading a beat and returns one
// temperature in whole degrees Celsius a beat, in the order the readings came
// in. A new reading can be taken in every clock cycle when the output is not
// held back. A reading passes in order through the register that holds the
// matching segment, the register that holds the product of position and
// temperature step, the stages of the restoring divider that yields one
// quotient bit in each stage, and the final add into the output register.
// Readings above the top of the table, or at or below its bottom, give a
// temperature of zero with the out-of-range flag set. When the output is
// stalled the pipeline fills up and then stops taking readings, and nothing
// inside is lost or repeated. Only the first NUM_SEGMENTS rows of the table
// are searched; a value beyond the table size searches the whole table.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature #(
    parameter int NUM_SEGMENTS = tatc_pkg::NUM_SEGMENTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    tatc_sample_if.sink adc,
    tatc_temp_if.source result
);
    import tatc_pkg::*;

    // Handshake between the segment match and the divider.
    logic       prod_valid;
    logic       prod_ready;
    tatc_prod_t prod;

    // Handshake between the divider and the output register.
    logic       quot_valid;
    logic       quot_ready;
    tatc_quot_t quot;

    // Output register.
    logic                     out_valid_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [TEMP_W-1:0] temp_next;
    logic                     oor_reg;

    tatc_seg_match #(
        .NUM_SEGMENTS (NUM_SEGMENTS)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (adc.valid),
        .in_ready  (adc.ready),
        .in_sample (adc.adc_sample),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_prod  (prod)
    );

    tatc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_prod   (prod),
        .out_valid (quot_valid),
        .out_ready (quot_ready),
        .out_quot  (quot)
    );

    // The output register takes a new beat whenever it is empty or its
    // current beat is being taken, so a waiting result blocks the pipeline
    // only until it is handed over.
    assign quot_ready = !out_valid_reg || result.ready;

    // The quotient never exceeds the temperature step of a segment, so the
    // add stays within the eight-bit range.
    always_comb
    begin
        if (quot.hit)
        begin
            temp_next = quot.t_lo + TEMP_W'(quot.quot);
        end
        else
        begin
            temp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (quot_ready)
        begin
            out_valid_reg <= quot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quot_ready && quot_valid)
        begin
            temp_reg <= temp_next;
            oor_reg  <= !quot.hit;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.temperature_c = temp_reg;
    assign result.out_of_range  = oor_reg;

    // An in-range result lies within the temperatures that the table covers.
    a_temp_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !oor_reg) |->
            ((temp_reg >= SEG_TABLE[0].t_lo) &&
             (temp_reg <= SEG_TABLE[TABLE_ROWS-1].t_hi)))
        else $error("in-range temperature outside the table");

    // An out-of-range result always carries a zero temperature.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && oor_reg) |-> (temp_reg == '0))
        else $error("out-of-range result with non-zero temperature");

endmodule

>>> design/tatc_seg_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment match and multiply
// Stage one finds the first matching segment; stage two forms the product.
// ----------------------------------------------------------------------------
module tatc_seg_match #(
    parameter int NUM_SEGMENTS = tatc_pkg::NUM_SEGMENTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tatc_pkg::SAMPLE_W-1:0] in_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tatc_pkg::tatc_prod_t          out_prod
);
    import tatc_pkg::*;

    localparam int ACTIVE = (NUM_SEGMENTS < TABLE_ROWS) ? NUM_SEGMENTS : TABLE_ROWS;

    logic                 s1_valid_reg;
    logic [SAMPLE_W-1:0]  s1_sample_reg;
    logic [TBL_IDX_W-1:0] s1_idx_reg;
    logic [TBL_IDX_W-1:0] s1_idx_next;
    logic                 s1_hit_reg;
    logic                 s1_hit_next;
    logic                 s1_ready;

    logic                 s2_valid_reg;
    tatc_prod_t           s2_prod_reg;
    tatc_prod_t           s2_prod_next;
    logic                 s2_ready;

    seg_row_t             row;
    logic [ADC_W-1:0]     diff;
    logic [TDIFF_W-1:0]   tdiff;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_prod  = s2_prod_reg;

    // Walk downwards so that the lowest matching row wins on a shared boundary.
    always_comb
    begin
        s1_idx_next = '0;
        s1_hit_next = 1'b0;
        for (int i = ACTIVE - 1; i >= 0; i--)
        begin
            if ((in_sample > SAMPLE_W'(SEG_TABLE[i].a_lo)) &&
                (in_sample <= SAMPLE_W'(SEG_TABLE[i].a_hi)))
            begin
                s1_idx_next = TBL_IDX_W'(i);
                s1_hit_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        row   = SEG_TABLE[s1_idx_reg];
        diff  = row.a_hi - s1_sample_reg[ADC_W-1:0];
        tdiff = TDIFF_W'(row.t_hi - row.t_lo);
        s2_prod_next.num  = NUM_W'(diff) * NUM_W'(tdiff);
        s2_prod_next.span = row.a_hi - row.a_lo;
        s2_prod_next.t_lo = row.t_lo;
        s2_prod_next.hit  = s1_hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_sample_reg <= in_sample;
            s1_idx_reg    <= s1_idx_next;
            s1_hit_reg    <= s1_hit_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_reg <= s2_prod_next;
        end
    end

    // A match always lies inside the span covered by the searched rows.
    a_hit_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_hit_reg) |->
            ((s1_sample_reg > SAMPLE_W'(SEG_TABLE[ACTIVE-1].a_lo)) &&
             (s1_sample_reg <= SAMPLE_W'(SEG_TABLE[0].a_hi))))
        else $error("matched sample lies outside the searched segments");

endmodule

>>> design/tatc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per stage, most significant bit first.
// ----------------------------------------------------------------------------
module tatc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tatc_pkg::tatc_prod_t in_prod,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tatc_pkg::tatc_quot_t out_quot
);
    import tatc_pkg::*;

    logic       st_valid_reg [QUOT_W];
    div_stage_t st_reg       [QUOT_W];
    div_stage_t st_next      [QUOT_W];
    div_stage_t st_in        [QUOT_W];
    logic       st_vin       [QUOT_W];
    logic       st_ready     [QUOT_W];

    assign in_ready       = st_ready[0];
    assign out_valid      = st_valid_reg[QUOT_W-1];
    assign out_quot.quot  = st_reg[QUOT_W-1].quot;
    assign out_quot.t_lo  = st_reg[QUOT_W-1].t_lo;
    assign out_quot.hit   = st_reg[QUOT_W-1].hit;

    always_comb
    begin
        st_in[0].rem  = DIV_W'(in_prod.num);
        st_in[0].quot = '0;
        st_in[0].span = in_prod.span;
        st_in[0].t_lo = in_prod.t_lo;
        st_in[0].hit  = in_prod.hit;
        st_vin[0]     = in_valid;
    end

    for (genvar s = 0; s < QUOT_W; s++)
    begin : g_stage
        localparam int SH = QUOT_W - 1 - s;

        logic [DIV_W-1:0] divisor;

        if (s > 0)
        begin : g_link
            assign st_in[s]  = st_reg[s-1];
            assign st_vin[s] = st_valid_reg[s-1];
        end

        if (s == QUOT_W - 1)
        begin : g_last
            assign st_ready[s] = !st_valid_reg[s] || out_ready;
        end
        else
        begin : g_mid
            assign st_ready[s] = !st_valid_reg[s] || st_ready[s+1];
        end

        assign divisor = DIV_W'(st_in[s].span) << SH;

        always_comb
        begin
            st_next[s] = st_in[s];
            if (st_in[s].rem >= divisor)
            begin
                st_next[s].rem      = st_in[s].rem - divisor;
                st_next[s].quot[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[s] <= 1'b0;
            end
            else if (st_ready[s])
            begin
                st_valid_reg[s] <= st_vin[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (st_ready[s] && st_vin[s])
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    // After the last bit the remainder is below the divisor for a real segment.
    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg[QUOT_W-1] && st_reg[QUOT_W-1].hit) |->
            (st_reg[QUOT_W-1].rem < DIV_W'(st_reg[QUOT_W-1].span)))
        else $error("divider remainder not below the segment span");

endmodule
